[hw/rtl/rra_pkg.sv]
// Shared constants and default parameter values for the rescaled range average block.
package rra_pkg;

   localparam int MAX_BOX_LOG2_DEF    = 12;
   localparam int SAMPLE_WIDTH_DEF    = 16;
   localparam int BOX_COUNT_WIDTH_DEF = 20;

   localparam int CFG_W     = 4;
   localparam int BOX_LOG2_RESET = 3;
   localparam int RS_W      = 28;
   localparam int ACC_W     = 48;
   localparam int FRAC_W    = 32;

   localparam logic [RS_W-1:0]  RS_MAX  = '1;
   localparam logic [ACC_W-1:0] ACC_MAX = '1;

endpackage

[hw/rtl/rra_box_mem.sv]
// Box sample store: one write port, one read port with registered read data.
module rra_box_mem #(
   parameter int ADDR_W = 12,
   parameter int DATA_W = 16
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[hw/rtl/rra_div.sv]
// Restoring divider, one quotient bit per cycle, low quotient bits plus an overflow flag.
module rra_div #(
   parameter int N_W = 128,
   parameter int D_W = 67,
   parameter int Q_W = 56
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [N_W-1:0] dividend,
   input  logic [D_W-1:0] divisor,
   output logic           done,
   output logic [Q_W-1:0] quotient,
   output logic           overflow
);

   localparam int CNT_W = $clog2(N_W);

   logic [N_W-1:0]   num_ff, num_in;
   logic [D_W:0]     rem_ff, rem_in;
   logic [D_W-1:0]   div_ff, div_in;
   logic [Q_W-1:0]   quo_ff, quo_in;
   logic             ovf_ff, ovf_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [D_W:0]     rem_sh;
   logic             ge;

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      ovf_in  = ovf_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff[D_W-1:0], num_ff[N_W-1]};
      ge      = (rem_sh >= {1'b0, div_ff});
      if (start) begin
         num_in = dividend;
         div_in = divisor;
         rem_in = '0;
         quo_in = '0;
         ovf_in = 1'b0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = ge ? (rem_sh - {1'b0, div_ff}) : rem_sh;
         num_in = {num_ff[N_W-2:0], 1'b0};
         quo_in = {quo_ff[Q_W-2:0], ge};
         ovf_in = ovf_ff | quo_ff[Q_W-1];
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(N_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
      ovf_ff <= ovf_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
   assign overflow = ovf_ff;

endmodule

[hw/rtl/rra_sqrt.sv]
// Integer square root, one result bit per cycle.
module rra_sqrt #(
   parameter int R_W = 28
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [2*R_W-1:0] operand,
   output logic             done,
   output logic [R_W-1:0]   root
);

   localparam int CNT_W = $clog2(R_W);

   logic [2*R_W-1:0] op_ff, op_in;
   logic [R_W+1:0]   rem_ff, rem_in;
   logic [R_W-1:0]   root_ff, root_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [R_W+1:0]   rem_sh;
   logic [R_W+1:0]   trial;
   logic             ge;

   always_comb begin
      op_in   = op_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff[R_W-1:0], op_ff[2*R_W-1 -: 2]};
      trial   = {root_ff, 2'b01};
      ge      = (rem_sh >= trial);
      if (start) begin
         op_in   = operand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         rem_in  = ge ? (rem_sh - trial) : rem_sh;
         root_in = {root_ff[R_W-2:0], ge};
         op_in   = {op_ff[2*R_W-3:0], 2'b00};
         cnt_in  = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(R_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

[hw/rtl/rescaled_range_average_core.sv]
// A sample that neither closes a box nor ends the set is taken with busy staying low.
// A box-closing sample holds busy through the store scan, the range and its shift-and-add
// square, the serial divide, the root and the update (a flat box skips the multiply, divide
// and root); a last sample then adds a serial divide for the average, skipped when there is
// no full box. The result strobe comes as busy falls and cannot be stalled.
// Synchronous reset clears the set; box_size_log2 = 3.
module rescaled_range_average_core #(
   parameter int MAX_BOX_LOG2    = rra_pkg::MAX_BOX_LOG2_DEF,
   parameter int SAMPLE_WIDTH    = rra_pkg::SAMPLE_WIDTH_DEF,
   parameter int BOX_COUNT_WIDTH = rra_pkg::BOX_COUNT_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic signed [SAMPLE_WIDTH-1:0]   req_sample,
   input  logic                             req_last,
   input  logic                             csr_write_en,
   input  logic [rra_pkg::CFG_W-1:0]        csr_write_data,
   output logic                             rsp_valid,
   output logic [rra_pkg::RS_W-1:0]         rsp_rs_average,
   output logic [BOX_COUNT_WIDTH-1:0]       rsp_box_count,
   output logic                             rsp_no_full_box,
   output logic                             rsp_flat_box_seen
);

   import rra_pkg::*;

   // Working widths. Deviations are kept scaled by the box size, so all
   // arithmetic is exact integer arithmetic.
   localparam int SW    = SAMPLE_WIDTH;
   localparam int L     = MAX_BOX_LOG2;
   localparam int BCW   = BOX_COUNT_WIDTH;
   localparam int KW    = $clog2(L + 1);
   localparam int SUM_W = SW + L + 1;
   localparam int SQ_W  = 2 * SW + L;
   localparam int Q_W   = 2 * SW + 3 * L;
   localparam int D_W   = SW + L + 2;
   localparam int C_W   = SW + 2 * L + 2;
   localparam int P_W   = 2 * C_W;
   localparam int NUM_W = P_W + L + FRAC_W;
   localparam int DN_W  = (NUM_W > ACC_W) ? NUM_W : ACC_W;
   localparam int DD_W  = (Q_W > BCW) ? Q_W : BCW;
   localparam int QT_W  = 2 * RS_W;
   localparam int MC_W  = $clog2(C_W);
   localparam logic [L:0] ONE_B = 1;

   typedef enum logic [12:0] {
      ST_IDLE   = 13'b0000000000001,
      ST_SQR    = 13'b0000000000010,
      ST_SCAN   = 13'b0000000000100,
      ST_DRAIN  = 13'b0000000001000,
      ST_RANGE  = 13'b0000000010000,
      ST_MUL    = 13'b0000000100000,
      ST_DIVB   = 13'b0000001000000,
      ST_SQRT   = 13'b0000010000000,
      ST_ACC    = 13'b0000100000000,
      ST_BOXEND = 13'b0001000000000,
      ST_AVG    = 13'b0010000000000,
      ST_AVGW   = 13'b0100000000000,
      ST_EMIT   = 13'b1000000000000
   } state_type;

   // Control state.
   state_type            state_ff, state_in;
   logic [CFG_W-1:0]     box_log2_ff, box_log2_in;
   logic [L:0]           fill_ff, fill_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [SQ_W-1:0]      sumsq_ff, sumsq_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [BCW-1:0]       full_ff, full_in;
   logic                 flat_ff, flat_in;
   logic                 last_ff, last_in;
   logic                 rvalid_ff;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Box processing datapath.
   logic [2*SUM_W-1:0]   sq_ff, sq_in;
   logic [Q_W-1:0]       q_ff, q_in;
   logic [L:0]           cnt_ff, cnt_in;
   logic signed [C_W-1:0] run_ff, run_in, hi_ff, hi_in, lo_ff, lo_in;
   logic [P_W-1:0]       mcand_ff, mcand_in, prod_ff, prod_in;
   logic [C_W-1:0]       mplier_ff, mplier_in;
   logic [MC_W-1:0]      mcnt_ff, mcnt_in;
   logic [RS_W-1:0]      y_ff, y_in, avg_ff, avg_in;
   logic [RS_W-1:0]      rsp_avg_ff, rsp_avg_in;
   logic [BCW-1:0]       rsp_cnt_ff, rsp_cnt_in;
   logic                 rsp_none_ff, rsp_none_in, rsp_flat_ff, rsp_flat_in;

   logic [KW-1:0]        k;
   logic [L:0]           box_size;
   logic                 accept;
   logic signed [2*SW-1:0] xsq;
   logic [SW-1:0]        rd_data;
   logic                 rd_en;
   logic signed [D_W-1:0] xe, se, dval;
   logic signed [C_W-1:0] run_next;
   logic [C_W-1:0]       range;
   logic [Q_W-1:0]       q_calc;
   logic [ACC_W:0]       acc_sum;

   logic                 div_start, div_done, div_ovf;
   logic [DN_W-1:0]      div_dividend;
   logic [DD_W-1:0]      div_divisor;
   logic [QT_W-1:0]      div_quo;
   logic                 sqrt_start, sqrt_done;
   logic [RS_W-1:0]      sqrt_root;

   // Effective box size: a register value below one or above the largest
   // supported box is pinned to the nearest legal value.
   always_comb begin
      if (box_log2_ff == '0) begin
         k = KW'(1);
      end else if (int'(box_log2_ff) > L) begin
         k = KW'(L);
      end else begin
         k = KW'(box_log2_ff);
      end
   end

   assign box_size = ONE_B << k;
   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign xsq      = req_sample * req_sample;

   // Deviation of one stored sample from the box mean, scaled by the box size.
   assign xe    = {{(D_W - SW){rd_data[SW-1]}}, rd_data};
   assign se    = {{(D_W - SUM_W){sum_ff[SUM_W-1]}}, sum_ff};
   assign dval  = (xe <<< k) - se;
   assign run_next = run_ff + {{(C_W - D_W){dval[D_W-1]}}, dval};
   assign range = hi_ff - lo_ff;

   // Sum of squared scaled deviations: B * (B * sum(x^2) - S^2).
   assign q_calc  = ((Q_W'(sumsq_ff) << k) - Q_W'(sq_ff)) << k;
   assign acc_sum = {1'b0, acc_ff} + (ACC_W + 1)'(y_ff);

   // The divider serves the per-box quotient R'^2*B*2^32 / Q and the final
   // average over the accumulated boxes.
   assign div_dividend = (state_ff == ST_MUL) ? (DN_W'(prod_in) << (k + FRAC_W))
                                              : DN_W'(acc_ff);
   assign div_divisor  = (state_ff == ST_MUL) ? DD_W'(q_ff) : DD_W'(full_ff);

   always_comb begin
      state_in     = state_ff;
      box_log2_in  = box_log2_ff;
      fill_in      = fill_ff;
      sum_in       = sum_ff;
      sumsq_in     = sumsq_ff;
      acc_in       = acc_ff;
      full_in      = full_ff;
      flat_in      = flat_ff;
      last_in      = last_ff;
      rsp_valid_in = 1'b0;
      sq_in        = sq_ff;
      q_in         = q_ff;
      cnt_in       = cnt_ff;
      run_in       = run_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      prod_in      = prod_ff;
      mcnt_in      = mcnt_ff;
      y_in         = y_ff;
      avg_in       = avg_ff;
      rsp_avg_in   = rsp_avg_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_none_in  = rsp_none_ff;
      rsp_flat_in  = rsp_flat_ff;
      rd_en        = 1'b0;
      div_start    = 1'b0;
      sqrt_start   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               fill_in  = fill_ff + ONE_B;
               sum_in   = sum_ff + {{(L + 1){req_sample[SW-1]}}, req_sample};
               sumsq_in = sumsq_ff + {{L{1'b0}}, xsq};
               last_in  = req_last;
               if (fill_ff + ONE_B == box_size) begin
                  // A box just closed. Once the count is saturated the box
                  // is dropped without being counted or accumulated.
                  if (full_ff == '1) begin
                     state_in = ST_BOXEND;
                  end else begin
                     full_in  = full_ff + BCW'(1);
                     state_in = ST_SQR;
                  end
               end else if (req_last) begin
                  state_in = ST_AVG;
               end
            end
         end
         ST_SQR: begin
            sq_in    = sum_ff * sum_ff;
            run_in   = '0;
            hi_in    = '0;
            lo_in    = '0;
            cnt_in   = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            rd_en  = 1'b1;
            cnt_in = cnt_ff + ONE_B;
            if (cnt_ff == box_size - ONE_B) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            q_in     = q_calc;
            state_in = ST_RANGE;
         end
         ST_RANGE: begin
            if (q_ff == '0) begin
               flat_in  = 1'b1;
               state_in = ST_BOXEND;
            end else begin
               mcand_in  = P_W'(range);
               mplier_in = range;
               prod_in   = '0;
               mcnt_in   = '0;
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            // Shift-and-add square of the range, one multiplier bit a cycle.
            if (mplier_ff[0]) begin
               prod_in = prod_ff + mcand_ff;
            end
            mcand_in  = {mcand_ff[P_W-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[C_W-1:1]};
            mcnt_in   = mcnt_ff + MC_W'(1);
            if (mcnt_ff == MC_W'(C_W - 1)) begin
               div_start = 1'b1;
               state_in  = ST_DIVB;
            end
         end
         ST_DIVB: begin
            if (div_done) begin
               if (div_ovf) begin
                  y_in     = RS_MAX;
                  state_in = ST_ACC;
               end else begin
                  sqrt_start = 1'b1;
                  state_in   = ST_SQRT;
               end
            end
         end
         ST_SQRT: begin
            if (sqrt_done) begin
               y_in     = sqrt_root;
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            acc_in   = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
            state_in = ST_BOXEND;
         end
         ST_BOXEND: begin
            fill_in  = '0;
            sum_in   = '0;
            sumsq_in = '0;
            state_in = last_ff ? ST_AVG : ST_IDLE;
         end
         ST_AVG: begin
            if (full_ff == '0) begin
               avg_in   = '0;
               state_in = ST_EMIT;
            end else begin
               div_start = 1'b1;
               state_in  = ST_AVGW;
            end
         end
         ST_AVGW: begin
            if (div_done) begin
               if (div_ovf || (div_quo[QT_W-1:RS_W] != '0)) begin
                  avg_in = RS_MAX;
               end else begin
                  avg_in = div_quo[RS_W-1:0];
               end
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_avg_in   = avg_ff;
            rsp_cnt_in   = full_ff;
            rsp_none_in  = (full_ff == '0);
            rsp_flat_in  = flat_ff;
            fill_in      = '0;
            sum_in       = '0;
            sumsq_in     = '0;
            acc_in       = '0;
            full_in      = '0;
            flat_in      = 1'b0;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Running cumulative deviation and its extremes, fed by the store
      // in the cycle after each read.
      if (rvalid_ff) begin
         run_in = run_next;
         if (run_next > hi_ff) begin
            hi_in = run_next;
         end
         if (run_next < lo_ff) begin
            lo_in = run_next;
         end
      end

      // A register write starts a fresh data set.
      if (csr_write_en) begin
         box_log2_in = csr_write_data;
         fill_in     = '0;
         sum_in      = '0;
         sumsq_in    = '0;
         acc_in      = '0;
         full_in     = '0;
         flat_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         box_log2_ff  <= CFG_W'(BOX_LOG2_RESET);
         fill_ff      <= '0;
         sum_ff       <= '0;
         sumsq_ff     <= '0;
         acc_ff       <= '0;
         full_ff      <= '0;
         flat_ff      <= 1'b0;
         last_ff      <= 1'b0;
         rvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         box_log2_ff  <= box_log2_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         sumsq_ff     <= sumsq_in;
         acc_ff       <= acc_in;
         full_ff      <= full_in;
         flat_ff      <= flat_in;
         last_ff      <= last_in;
         rvalid_ff    <= rd_en;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sq_ff       <= sq_in;
      q_ff        <= q_in;
      cnt_ff      <= cnt_in;
      run_ff      <= run_in;
      hi_ff       <= hi_in;
      lo_ff       <= lo_in;
      mcand_ff    <= mcand_in;
      mplier_ff   <= mplier_in;
      prod_ff     <= prod_in;
      mcnt_ff     <= mcnt_in;
      y_ff        <= y_in;
      avg_ff      <= avg_in;
      rsp_avg_ff  <= rsp_avg_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_none_ff <= rsp_none_in;
      rsp_flat_ff <= rsp_flat_in;
   end

   rra_box_mem #(
      .ADDR_W (L),
      .DATA_W (SW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (fill_ff[L-1:0]),
      .wr_data (req_sample),
      .rd_en   (rd_en),
      .rd_addr (cnt_ff[L-1:0]),
      .rd_data (rd_data)
   );

   rra_div #(
      .N_W (DN_W),
      .D_W (DD_W),
      .Q_W (QT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo),
      .overflow (div_ovf)
   );

   rra_sqrt #(
      .R_W (RS_W)
   ) u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sqrt_start),
      .operand (div_quo),
      .done    (sqrt_done),
      .root    (sqrt_root)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_rs_average    = rsp_avg_ff;
   assign rsp_box_count     = rsp_cnt_ff;
   assign rsp_no_full_box   = rsp_none_ff;
   assign rsp_flat_box_seen = rsp_flat_ff;

endmodule

[hw/rtl/rra_checker.sv]
// Port-level checks of the rescaled range average core, bound to the top level.
module rra_checker #(
   parameter int BOX_COUNT_WIDTH = rra_pkg::BOX_COUNT_WIDTH_DEF
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           busy,
   input logic                           rsp_valid,
   input logic [rra_pkg::RS_W-1:0]       rsp_rs_average,
   input logic [BOX_COUNT_WIDTH-1:0]     rsp_box_count,
   input logic                           rsp_no_full_box,
   input logic                           rsp_flat_box_seen
);

   import rra_pkg::*;

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_idle_on_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy && $past(busy))
      else $error("result transfer not at the end of a busy period");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_no_full_box == (rsp_box_count == '0)))
      else $error("no_full_box disagrees with box count");

   a_empty_average: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_full_box |-> (rsp_rs_average == '0) && !rsp_flat_box_seen)
      else $error("empty data set with nonzero average or flat flag");

endmodule

bind rescaled_range_average_core rra_checker #(
   .BOX_COUNT_WIDTH (BOX_COUNT_WIDTH)
) u_rra_checker (.*);
